/* rtl/idle_sleep_motion_wake_defines.svh */
// assertion macros for the display sleep controller
// included by the core and the top level; no other dependencies
`ifndef IDLE_SLEEP_MOTION_WAKE_DEFINES_SVH
`define IDLE_SLEEP_MOTION_WAKE_DEFINES_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ISMW_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("ismw: same-cycle check failed");
// antecedent implies consequent in the next cycle
`define ISMW_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("ismw: next-cycle check failed");
`else
`define ISMW_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define ISMW_ASSERT_NXT(lbl, ck, rn, ante, cons)
`endif
`endif

/* rtl/ismw_pkg.sv */
// shared types and constants of the display sleep controller
// no dependencies; imported by ismw_core and idle_sleep_motion_wake
`timescale 1ns / 1ps
package ismw_pkg;

	localparam int TIME_BITS   = 48;
	localparam int SAMPLE_BITS = 16;
	localparam int TMO_BITS    = 8;
	localparam int THR_BITS    = 12;
	localparam int MPM_BITS    = 16;
	localparam int LIMIT_BITS  = TMO_BITS + MPM_BITS;
	localparam int MAG_BITS    = (SAMPLE_BITS + 1 > THR_BITS) ? SAMPLE_BITS + 1 : THR_BITS;

	localparam logic [MPM_BITS-1:0] MS_PER_MINUTE   = 16'd60000;
	localparam logic [THR_BITS-1:0] THRESHOLD_RESET = 12'd200;

	// stream payload widths; the data fields are whole bytes
	localparam int IN_RAW_BITS   = TIME_BITS + 3 * SAMPLE_BITS;
	localparam int IN_DATA_BITS  = ((IN_RAW_BITS + 7) / 8) * 8;
	localparam int IN_USER_BITS  = 3;
	localparam int OUT_DATA_BITS = 8;
	localparam int OUT_USER_BITS = 2;

	// configuration port
	localparam int APB_ADDR_BITS = 3;
	localparam int APB_DATA_BITS = 32;
	localparam logic REG_IDLE_TIMEOUT = 1'b0;
	localparam logic REG_MOTION_THR   = 1'b1;

	typedef enum logic [1:0] {
		ACT_POLL      = 2'd0,
		ACT_ACTIVITY  = 2'd1,
		ACT_FORCE_OFF = 2'd2
	} action_e;

	typedef enum logic [1:0] {
		TR_NONE        = 2'd0,
		TR_WENT_OFF    = 2'd1,
		TR_WAKE_REQ    = 2'd2,
		TR_WAKE_MOTION = 2'd3
	} transition_e;

	typedef struct packed {
		logic [1:0]                    action;
		logic [TIME_BITS-1:0]          time_ms;
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
		logic                          accel_valid;
	} item_t;

	typedef struct packed {
		logic        display_off;
		transition_e transition;
	} result_t;

	typedef struct packed {
		logic [TMO_BITS-1:0] idle_timeout_minutes;
		logic [THR_BITS-1:0] motion_threshold_mg;
	} cfg_t;

endpackage

/* rtl/idle_sleep_motion_wake.sv */
// top level of the display sleep controller: stream ports, register port, pipeline
// depends on ismw_pkg, ismw_core and idle_sleep_motion_wake_defines.svh
`timescale 1ns / 1ps
// usage
//   input stream s_*: one transfer per event (poll, activity, force off) with the
//   uptime in ms and one accelerometer sample; output stream m_*: one transfer per
//   input transfer, in order, giving the blanked state and the transition taken
//   apb port: idle timeout in minutes at 0x0, motion threshold in mg at 0x4;
//   write only while the block is idle
// path: the input register takes the transfer; decision and state update feed
//   the output register that drives m_tvalid; a low m_tready stalls between them
// throughput: 1 transfer per cycle while m_tready is high; the 48-bit idle
//   subtract/compare and the three per-axis deviation checks sit in the single
//   stage between the two registers
// reset: display on, no pending wake, last activity at time 0, no rest sample,
//   timeout 0 (no idle blanking), threshold 200 mg; both pipeline slots empty
// stall: while m_tready is low the output register holds its result, the input
//   register fills, and s_tready drops once both are occupied
`include "idle_sleep_motion_wake_defines.svh"
module idle_sleep_motion_wake (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// time_ms[47:0], accel_x[63:48], accel_y[79:64], accel_z[95:80]
	input  logic [ismw_pkg::IN_DATA_BITS-1:0]    s_tdata,
	// action[1:0], accel_valid[2]
	input  logic [ismw_pkg::IN_USER_BITS-1:0]    s_tuser,
	// output stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// display_off[0], zero fill [7:1]
	output logic [ismw_pkg::OUT_DATA_BITS-1:0]   m_tdata,
	// transition[1:0]
	output logic [ismw_pkg::OUT_USER_BITS-1:0]   m_tuser,
	// register port
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [ismw_pkg::APB_ADDR_BITS-1:0]   paddr,
	input  logic [ismw_pkg::APB_DATA_BITS-1:0]   pwdata,
	output logic [ismw_pkg::APB_DATA_BITS-1:0]   prdata,
	output logic                                 pready
);
	import ismw_pkg::*;

	cfg_t    cfg_q;
	logic    cfg_wr;
	logic    reg_sel;

	item_t   item_s1;
	logic    valid_s1;
	logic    advance;
	result_t res;
	result_t res_q;
	logic    m_valid_q;

	// register port: word select from address bit 2, writes in the access phase
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout_minutes <= '0;
			cfg_q.motion_threshold_mg  <= THRESHOLD_RESET;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_IDLE_TIMEOUT: cfg_q.idle_timeout_minutes <= pwdata[TMO_BITS-1:0];
				REG_MOTION_THR:   cfg_q.motion_threshold_mg  <= pwdata[THR_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_IDLE_TIMEOUT: prdata = APB_DATA_BITS'(cfg_q.idle_timeout_minutes);
			REG_MOTION_THR:   prdata = APB_DATA_BITS'(cfg_q.motion_threshold_mg);
			default:          prdata = '0;
		endcase
	end

	// the input slot moves on whenever the output register is free or draining
	assign advance  = valid_s1 && (!m_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input payload unpacked from the stream fields
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.action      <= s_tuser[1:0];
			item_s1.accel_valid <= s_tuser[2];
			item_s1.time_ms     <= s_tdata[TIME_BITS-1:0];
			item_s1.accel_x     <= s_tdata[TIME_BITS +: SAMPLE_BITS];
			item_s1.accel_y     <= s_tdata[TIME_BITS + SAMPLE_BITS +: SAMPLE_BITS];
			item_s1.accel_z     <= s_tdata[TIME_BITS + 2 * SAMPLE_BITS +: SAMPLE_BITS];
		end
	end

	// decision and sleep state; state commits only when the item moves on
	ismw_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.res    (res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {{(OUT_DATA_BITS - 1){1'b0}}, res_q.display_off};
	assign m_tuser  = res_q.transition;

	`ISMW_ASSERT_IMP(a_ready_when_out_free, clk, arst_n, !m_valid_q, s_tready)
	`ISMW_ASSERT_NXT(a_accept_fills_slot, clk, arst_n, s_tvalid && s_tready, valid_s1)
	`ISMW_ASSERT_IMP(a_transition_matches_state, clk, arst_n,
		m_valid_q && res_q.transition != TR_NONE,
		res_q.display_off == (res_q.transition == TR_WENT_OFF))

endmodule

/* rtl/ismw_core.sv */
// sleep state and per-item decision logic of the display sleep controller
// depends on ismw_pkg and idle_sleep_motion_wake_defines.svh
`timescale 1ns / 1ps
`include "idle_sleep_motion_wake_defines.svh"
module ismw_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  ismw_pkg::item_t  item,
	input  ismw_pkg::cfg_t   cfg,
	output ismw_pkg::result_t res
);
	import ismw_pkg::*;

	function automatic logic axis_moved(
		input logic [SAMPLE_BITS-1:0] now_v,
		input logic [SAMPLE_BITS-1:0] rest_v,
		input logic [THR_BITS-1:0]    thr
	);
		logic [SAMPLE_BITS:0] d;
		logic [SAMPLE_BITS:0] mag;
		d   = {now_v[SAMPLE_BITS-1], now_v} - {rest_v[SAMPLE_BITS-1], rest_v};
		mag = d[SAMPLE_BITS] ? (~d + 1'b1) : d;
		return MAG_BITS'(mag) > MAG_BITS'(thr);
	endfunction

	logic                   blanked_q, blanked_d;
	logic                   pend_q, pend_d;
	logic [TIME_BITS-1:0]   last_q, last_d;
	logic [SAMPLE_BITS-1:0] rest_x_q, rest_y_q, rest_z_q;
	logic [SAMPLE_BITS-1:0] rest_x_d, rest_y_d, rest_z_d;
	logic                   rest_valid_q, rest_valid_d;
	logic [LIMIT_BITS-1:0]  limit_raw;
	logic [TIME_BITS-1:0]   limit_q;
	logic [TIME_BITS:0]     idle_diff;
	logic                   idle_reached;
	logic                   moved;
	transition_e            trans;

	// idle limit in ms, registered off the multiplier
	assign limit_raw = LIMIT_BITS'(cfg.idle_timeout_minutes) * LIMIT_BITS'(MS_PER_MINUTE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else begin
			limit_q <= {{(TIME_BITS - LIMIT_BITS){1'b0}}, limit_raw};
		end
	end

	// borrow out means time went backwards: not idle
	assign idle_diff    = {1'b0, item.time_ms} - {1'b0, last_q};
	assign idle_reached = !idle_diff[TIME_BITS] && (idle_diff[TIME_BITS-1:0] >= limit_q);

	assign moved = rest_valid_q && item.accel_valid &&
		(axis_moved(item.accel_x, rest_x_q, cfg.motion_threshold_mg) ||
		 axis_moved(item.accel_y, rest_y_q, cfg.motion_threshold_mg) ||
		 axis_moved(item.accel_z, rest_z_q, cfg.motion_threshold_mg));

	always_comb begin
		blanked_d    = blanked_q;
		pend_d       = pend_q;
		last_d       = last_q;
		rest_x_d     = rest_x_q;
		rest_y_d     = rest_y_q;
		rest_z_d     = rest_z_q;
		rest_valid_d = rest_valid_q;
		trans        = TR_NONE;
		case (item.action)
			ACT_ACTIVITY: begin
				last_d = item.time_ms;
				if (blanked_q) begin
					pend_d = 1'b1;
				end
			end
			ACT_FORCE_OFF: begin
				if (!blanked_q) begin
					trans = TR_WENT_OFF;
				end
			end
			ACT_POLL: begin
				if (blanked_q) begin
					if (pend_q) begin
						trans = TR_WAKE_REQ;
					end else if (moved) begin
						trans = TR_WAKE_MOTION;
					end
				end else if (cfg.idle_timeout_minutes != '0 && idle_reached) begin
					trans = TR_WENT_OFF;
				end
			end
			default: begin
			end
		endcase
		case (trans)
			TR_WENT_OFF: begin
				blanked_d    = 1'b1;
				rest_x_d     = item.accel_x;
				rest_y_d     = item.accel_y;
				rest_z_d     = item.accel_z;
				rest_valid_d = item.accel_valid;
			end
			TR_WAKE_REQ, TR_WAKE_MOTION: begin
				blanked_d = 1'b0;
				pend_d    = 1'b0;
				last_d    = item.time_ms;
			end
			default: begin
			end
		endcase
	end

	assign res.display_off = blanked_d;
	assign res.transition  = trans;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blanked_q    <= 1'b0;
			pend_q       <= 1'b0;
			last_q       <= '0;
			rest_x_q     <= '0;
			rest_y_q     <= '0;
			rest_z_q     <= '0;
			rest_valid_q <= 1'b0;
		end else if (en) begin
			blanked_q    <= blanked_d;
			pend_q       <= pend_d;
			last_q       <= last_d;
			rest_x_q     <= rest_x_d;
			rest_y_q     <= rest_y_d;
			rest_z_q     <= rest_z_d;
			rest_valid_q <= rest_valid_d;
		end
	end

	`ISMW_ASSERT_IMP(a_pend_only_blanked, clk, arst_n, !blanked_q, !pend_q)
	`ISMW_ASSERT_NXT(a_off_sets_blanked, clk, arst_n,
		en && trans == TR_WENT_OFF, blanked_q && !$past(blanked_q))
	`ISMW_ASSERT_NXT(a_wake_stamps_time, clk, arst_n,
		en && (trans == TR_WAKE_REQ || trans == TR_WAKE_MOTION),
		!blanked_q && last_q == $past(item.time_ms))

endmodule
